// ----- rtl/core/sul_pkg.sv -----
// Shared types and constants for the sorted unique list.
`default_nettype none

package sul_pkg;

    localparam int KEY_W               = 32;
    localparam int CAP_W               = 5;
    localparam int DEFAULT_MAX_ENTRIES = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_DUMP   = 3'd3,
        ACT_COUNT  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_SEARCH = 2'd0,
        KIND_COUNT  = 2'd1,
        KIND_DUMP   = 2'd2
    } kind_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
        logic rotate;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/sul_cell.sv -----
// One slot of the sorted chain: holds a key, compares, shifts with its neighbors.
`default_nettype none

module sul_cell
    import sul_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
    parameter int INDEX       = 0,
    localparam int OCC_W      = $clog2(MAX_ENTRIES + 1)
)
(
    input  wire logic                    clk,
    input  wire cell_ctl_t               ctl,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic [OCC_W-1:0]        occ,
    input  wire logic                    left_le,
    input  wire logic signed [KEY_W-1:0] left_entry,
    input  wire logic signed [KEY_W-1:0] right_entry,
    input  wire logic signed [KEY_W-1:0] head_entry,
    output logic signed [KEY_W-1:0]      entry,
    output logic                         le,
    output logic                         eq
);

    logic signed [KEY_W-1:0] entry_reg;
    logic signed [KEY_W-1:0] entry_next;
    logic                    valid;
    logic                    is_last;
    logic                    ge;

    assign valid   = occ > OCC_W'(INDEX);
    assign is_last = occ == OCC_W'(INDEX + 1);

    assign entry = entry_reg;
    assign le    = valid && !(entry_reg > key);
    assign ge    = valid && !(entry_reg < key);
    assign eq    = valid && (entry_reg == key);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert)
        begin
            // keep if not greater, take key at the boundary, else shift up
            if (!le)
            begin
                entry_next = left_le ? key : left_entry;
            end
        end
        else if (ctl.remove)
        begin
            if (ge)
            begin
                entry_next = right_entry;
            end
        end
        else if (ctl.rotate)
        begin
            if (is_last)
            begin
                entry_next = head_entry;
            end
            else if (valid)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_unique_list.sv -----
// Top level of the sorted unique list: cell chain plus command sequencer.
`default_nettype none

// Sorted list of distinct signed Q16.16 keys, one key per cell of a chain.
// Command channel: an item (action, key) is taken on a clock edge where
// start is high and busy is low. Insert, remove, search and count are each
// decided on that edge: every cell compares the key against its own slot at
// once and, for insert and remove, the chain shifts up or down by one slot.
// Search and count answers appear on the result ports in the cycle after the
// item, with result_valid high for a single cycle and last set.
// Dump rotates the occupied part of the chain through cell 0, one slot per
// cycle: busy stays high until every occupied slot has passed, and the first
// min(occupancy, capacity) keys come out in ascending order on consecutive
// cycles via the dump state and result registers; last marks the final one.
// A dump that shows no key gives no result and keeps busy low.
// Insert and remove give no result. Undefined actions are dropped.
// The receiver cannot stall: each result is shown for exactly one cycle.
// The user must write capacity_in_use through capacity_we only while idle;
// the block does not enforce it. Values above MAX_ENTRIES act as MAX_ENTRIES.
// Reset empties the list (occupancy zero) and sets capacity to 16; the
// slot contents are not cleared, since only slots below occupancy are read.
module sorted_unique_list
    import sul_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              action,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic                    capacity_we,
    input  wire logic [CAP_W-1:0]        capacity_in_use,
    output logic                         result_valid,
    output logic [1:0]                   kind,
    output logic                         found,
    output logic [CAP_W-1:0]             occupancy_out,
    output logic signed [KEY_W-1:0]      entry_value,
    output logic                         last
);

    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // chain wiring
    logic signed [KEY_W-1:0] entry_w [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  le_w;
    logic [MAX_ENTRIES-1:0]  eq_w;
    cell_ctl_t               ctl;

    // control state
    state_t             state_reg,  state_next;
    logic [OCC_W-1:0]   occ_reg,    occ_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]   cnt_reg,    cnt_next;
    logic [OCC_W-1:0]   dump_n_reg, dump_n_next;

    // result registers
    logic                    rvalid_reg, rvalid_next;
    logic [1:0]              kind_reg,   kind_next;
    logic                    found_reg,  found_next;
    logic [CAP_W-1:0]        occo_reg,   occo_next;
    logic signed [KEY_W-1:0] value_reg,  value_next;
    logic                    last_reg,   last_next;

    logic             accept;
    logic             hit;
    logic [CW-1:0]    occ_ext;
    logic [CW-1:0]    cap_ext;
    logic [CW-1:0]    eff_cap;
    logic [OCC_W-1:0] dump_n;
    logic [OCC_W-1:0] cnt_inc;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic                    l_le;
            logic signed [KEY_W-1:0] l_entry;
            logic signed [KEY_W-1:0] r_entry;

            if (gi == 0)
            begin : g_head
                assign l_le    = 1'b1;
                assign l_entry = key;
            end
            else
            begin : g_mid
                assign l_le    = le_w[gi-1];
                assign l_entry = entry_w[gi-1];
            end

            if (gi == MAX_ENTRIES - 1)
            begin : g_tail
                assign r_entry = entry_w[gi];
            end
            else
            begin : g_body
                assign r_entry = entry_w[gi+1];
            end

            sul_cell #(
                .MAX_ENTRIES (MAX_ENTRIES),
                .INDEX       (gi)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .key         (key),
                .occ         (occ_reg),
                .left_le     (l_le),
                .left_entry  (l_entry),
                .right_entry (r_entry),
                .head_entry  (entry_w[0]),
                .entry       (entry_w[gi]),
                .le          (le_w[gi]),
                .eq          (eq_w[gi])
            );
        end
    endgenerate

    assign accept  = start && (state_reg == S_IDLE);
    assign hit     = |eq_w;
    assign occ_ext = CW'(occ_reg);
    assign cap_ext = CW'(cap_reg);
    assign eff_cap = (cap_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_ext;
    // keys shown by a dump: the occupancy, clipped to the capacity
    assign dump_n  = (occ_ext < eff_cap) ? occ_reg : OCC_W'(eff_cap);
    assign cnt_inc = cnt_reg + OCC_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        dump_n_next = dump_n_reg;
        ctl         = '0;
        rvalid_next = 1'b0;
        kind_next   = KIND_SEARCH;
        found_next  = 1'b0;
        occo_next   = '0;
        value_next  = '0;
        last_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_INSERT:
                        begin
                            if (!hit && (occ_ext < eff_cap))
                            begin
                                ctl.insert = 1'b1;
                                occ_next   = occ_reg + OCC_W'(1);
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (hit)
                            begin
                                ctl.remove = 1'b1;
                                occ_next   = occ_reg - OCC_W'(1);
                            end
                        end
                        ACT_SEARCH:
                        begin
                            rvalid_next = 1'b1;
                            kind_next   = KIND_SEARCH;
                            found_next  = hit;
                            last_next   = 1'b1;
                        end
                        ACT_DUMP:
                        begin
                            if (dump_n != '0)
                            begin
                                state_next  = S_DUMP;
                                cnt_next    = '0;
                                dump_n_next = dump_n;
                            end
                        end
                        ACT_COUNT:
                        begin
                            rvalid_next = 1'b1;
                            kind_next   = KIND_COUNT;
                            occo_next   = occ_ext[CAP_W-1:0];
                            last_next   = 1'b1;
                        end
                        default:
                        begin
                            // undefined action: dropped
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // head leaves through cell 0 and re-enters at the top slot
                ctl.rotate = 1'b1;
                cnt_next   = cnt_inc;
                if (cnt_reg < dump_n_reg)
                begin
                    rvalid_next = 1'b1;
                    kind_next   = KIND_DUMP;
                    value_next  = entry_w[0];
                    last_next   = (cnt_inc == dump_n_reg);
                end
                // full turn restores the order
                if (cnt_inc == occ_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            occ_reg    <= '0;
            cap_reg    <= CAP_RESET;
            cnt_reg    <= '0;
            dump_n_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            occ_reg    <= occ_next;
            cnt_reg    <= cnt_next;
            dump_n_reg <= dump_n_next;
            rvalid_reg <= rvalid_next;
            if (capacity_we)
            begin
                cap_reg <= capacity_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        found_reg <= found_next;
        occo_reg  <= occo_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign busy          = (state_reg == S_DUMP);
    assign result_valid  = rvalid_reg;
    assign kind          = kind_reg;
    assign found         = found_reg;
    assign occupancy_out = occo_reg;
    assign entry_value   = value_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sul_checker.sv -----
// Port-level checks for the sorted unique list, bound to the top level.
`default_nettype none

module sul_checker
    import sul_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic [2:0]              action,
    input wire logic                    result_valid,
    input wire logic [1:0]              kind,
    input wire logic                    found,
    input wire logic                    last
);

    // search and count answers are always single, so always last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind != KIND_DUMP) |-> last)
        else $error("single answer without last");

    a_found_search_only: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind != KIND_SEARCH) |-> !found)
        else $error("found set outside a search answer");

    a_search_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == ACT_SEARCH) |=> result_valid && (kind == KIND_SEARCH))
        else $error("search item without answer");

    a_count_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == ACT_COUNT) |=> result_valid && (kind == KIND_COUNT))
        else $error("count item without answer");

    // a dump that is not finished keeps the block busy
    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_DUMP) && !last |-> busy)
        else $error("dump stream open while idle");

endmodule

bind sorted_unique_list sul_checker u_sul_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .result_valid (result_valid),
    .kind         (kind),
    .found        (found),
    .last         (last)
);

`default_nettype wire

// ----- tb/sorted_unique_list_tb.sv -----
// Self-checking testbench for sorted_unique_list: directed table, then random phases.
`default_nettype none

module sorted_unique_list_tb;
    import sul_pkg::*;

    localparam int SLOTS        = DEFAULT_MAX_ENTRIES;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 25;         // 6 x 25 random items
    localparam int SETTLE       = 3;          // insert/remove finish on the accepting edge
    localparam int TAIL_CYCLES  = SLOTS + 4;  // longest dump rotation plus margin
    localparam int CYCLE_LIMIT  = 200000;

    // undefined action codes: the block must drop them silently
    localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_ZERO    = 32'sh0000_0000;
    localparam logic signed [KEY_W-1:0] KEY_NEG_ONE = 32'shFFFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_ONE     = 32'sh0001_0000;   // 1.0 in Q16.16

    // one answer as it should appear on the result ports
    typedef struct {
        kind_t                   kind;
        logic                    found;
        logic [CAP_W-1:0]        occ;
        logic signed [KEY_W-1:0] value;
        logic                    last;
    } answer_t;

    // one row of the directed table
    typedef struct {
        logic                    is_cfg;   // row rewrites capacity instead of sending an item
        logic [2:0]              act;
        logic signed [KEY_W-1:0] key;
        logic                    typed;    // answer written in the row, not predicted
        logic                    t_found;
        logic [CAP_W-1:0]        t_occ;
        logic [CAP_W-1:0]        cap;
    } step_row_t;

    localparam int NSTEPS = 30;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [2:0]              action;
    logic signed [KEY_W-1:0] key;
    logic                    capacity_we;
    logic [CAP_W-1:0]        capacity_in_use;
    logic                    result_valid;
    logic [1:0]              kind;
    logic                    found;
    logic [CAP_W-1:0]        occupancy_out;
    logic signed [KEY_W-1:0] entry_value;
    logic                    last;

    // travels with the item on the command port: the directed answer to use, if any
    logic                    typed_pending;
    logic                    typed_found;
    logic [CAP_W-1:0]        typed_occ;

    // mirror of the list, kept by the predictor
    logic signed [KEY_W-1:0] held_keys [SLOTS];
    int                      held_count;
    logic [CAP_W-1:0]        cap_setting;
    answer_t                 expected_answers [$];

    logic                    failed;
    int                      cycles;
    int                      burst_left;
    logic signed [KEY_W-1:0] key_pool [$];
    step_row_t               steps [NSTEPS];

    sorted_unique_list dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .key             (key),
        .capacity_we     (capacity_we),
        .capacity_in_use (capacity_in_use),
        .result_valid    (result_valid),
        .kind            (kind),
        .found           (found),
        .occupancy_out   (occupancy_out),
        .entry_value     (entry_value),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted item to the mirrored list and queue the answers it causes.
    function automatic void apply_list_op(input logic [2:0] act,
                                          input logic signed [KEY_W-1:0] k);
        int      pos;
        int      slot;
        int      lim;
        int      n;
        answer_t a;
        pos = -1;
        for (int i = 0; i < held_count; i++)
            if (pos < 0 && held_keys[i] == k)
                pos = i;
        // capacity above the slot count saturates
        lim = (int'(cap_setting) > SLOTS) ? SLOTS : int'(cap_setting);
        a.kind  = KIND_SEARCH;
        a.found = 1'b0;
        a.occ   = '0;
        a.value = '0;
        a.last  = 1'b1;
        case (act)
            ACT_INSERT:
            begin
                // duplicates and a full list (against capacity) are dropped
                if (pos < 0 && held_count < lim)
                begin
                    slot = 0;
                    while (slot < held_count && held_keys[slot] <= k)
                        slot++;
                    for (int j = held_count; j > slot; j--)
                        held_keys[j] = held_keys[j-1];
                    held_keys[slot] = k;
                    held_count++;
                end
            end
            ACT_REMOVE:
            begin
                if (pos >= 0)
                begin
                    for (int j = pos; j + 1 < held_count; j++)
                        held_keys[j] = held_keys[j+1];
                    held_count--;
                end
            end
            ACT_SEARCH:
            begin
                a.found = (pos >= 0);
                expected_answers.push_back(a);
            end
            ACT_DUMP:
            begin
                // only the first min(occupancy, capacity) keys come out
                n = (held_count < lim) ? held_count : lim;
                for (int i = 0; i < n; i++)
                begin
                    a.kind  = KIND_DUMP;
                    a.value = held_keys[i];
                    a.last  = (i == n - 1);
                    expected_answers.push_back(a);
                end
            end
            ACT_COUNT:
            begin
                a.kind = KIND_COUNT;
                a.occ  = CAP_W'(held_count);
                expected_answers.push_back(a);
            end
            default: ;
        endcase
    endfunction

    // Result check, config tracking and item acceptance, all sampled at the rising edge.
    always @(posedge clk)
    begin
        answer_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d answers still pending", $time, expected_answers.size());
            $display("** sorted_unique_list: FAILED **");
            $finish;
        end
        else if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d found=%0d occ=%0d value=%h last=%0d",
                             $time, kind, found, occupancy_out, entry_value, last);
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (kind !== want.kind)
                    begin
                        $display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
                        failed = 1'b1;
                    end
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0d got %0d", $time, want.found, found);
                        failed = 1'b1;
                    end
                    if (occupancy_out !== want.occ)
                    begin
                        $display("%0t: occupancy_out expected %0d got %0d",
                                 $time, want.occ, occupancy_out);
                        failed = 1'b1;
                    end
                    if (entry_value !== want.value)
                    begin
                        $display("%0t: entry_value expected %h got %h",
                                 $time, want.value, entry_value);
                        failed = 1'b1;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0d got %0d", $time, want.last, last);
                        failed = 1'b1;
                    end
                end
            end
            if (capacity_we)
                cap_setting = capacity_in_use;
            if (start && !busy)
            begin
                apply_list_op(action, key);
                // directed rows with a typed answer replace the predicted one
                if (typed_pending)
                begin
                    want = expected_answers.pop_back();
                    want.kind  = (action == ACT_COUNT) ? KIND_COUNT : KIND_SEARCH;
                    want.found = typed_found;
                    want.occ   = typed_occ;
                    expected_answers.push_back(want);
                end
            end
        end
    end

    // Gap before the next item: mostly random, with occasional back-to-back bursts.
    function automatic int next_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
            burst_left = $urandom_range(5, 20);
        return $urandom_range(0, 13);
    endfunction

    // Present one item from a falling edge and hold it until the block takes it.
    task automatic send_item(input logic [2:0] act, input logic signed [KEY_W-1:0] k,
                             input logic typed, input logic t_found,
                             input logic [CAP_W-1:0] t_occ, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start         <= 1'b1;
        action        <= act;
        key           <= k;
        typed_pending <= typed;
        typed_found   <= t_found;
        typed_occ     <= t_occ;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending, wait for every answer and for busy to drop, then let the block settle.
    task automatic wait_idle(input int settle);
        @(negedge clk);
        start <= 1'b0;
        while (expected_answers.size() != 0 || busy)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_idle(SETTLE);
        capacity_we     <= 1'b1;
        capacity_in_use <= cap;
        @(negedge clk);
        capacity_we     <= 1'b0;
    endtask

    initial
    begin
        logic [CAP_W-1:0]        phase_cap [PHASES];
        int                      insert_pct [PHASES];
        logic [2:0]              act;
        logic signed [KEY_W-1:0] k;
        int                      pick;

        start           = 1'b0;
        action          = ACT_INSERT;
        key             = '0;
        capacity_we     = 1'b0;
        capacity_in_use = '0;
        typed_pending   = 1'b0;
        typed_found     = 1'b0;
        typed_occ       = '0;
        failed          = 1'b0;
        cycles          = 0;
        burst_left      = 0;
        held_count      = 0;
        cap_setting     = CAP_RESET;
        for (int i = 0; i < SLOTS; i++)
            held_keys[i] = '0;

        // Directed part. Typed answers are the ones obvious by inspection.
        steps = '{
            '{1'b0, ACT_COUNT,    KEY_ZERO,      1'b1, 1'b0, 5'd0, 5'd0},  // empty after reset
            '{1'b0, ACT_SEARCH,   KEY_ZERO,      1'b1, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_DUMP,     KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd0},  // empty dump: silent
            '{1'b0, ACT_REMOVE,   KEY_ONE,       1'b0, 1'b0, 5'd0, 5'd0},  // absent key
            '{1'b0, ACT_INSERT,   KEY_MAX,       1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_INSERT,   KEY_MIN,       1'b0, 1'b0, 5'd0, 5'd0},  // goes below all
            '{1'b0, ACT_INSERT,   KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_INSERT,   KEY_NEG_ONE,   1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_INSERT,   KEY_ONE,       1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_INSERT,   KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd0},  // duplicate
            '{1'b0, ACT_COUNT,    KEY_ZERO,      1'b1, 1'b0, 5'd5, 5'd0},
            '{1'b0, ACT_SEARCH,   KEY_MIN,       1'b1, 1'b1, 5'd0, 5'd0},
            '{1'b0, ACT_SEARCH,   KEY_MAX - 1,   1'b1, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_DUMP,     KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_REMOVE,   KEY_MIN,       1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_REMOVE,   KEY_MAX,       1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_REMOVE,   KEY_MAX,       1'b0, 1'b0, 5'd0, 5'd0},  // already gone
            '{1'b0, ACT_UNDEF_LO, KEY_NEG_ONE,   1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_UNDEF_HI, KEY_NEG_ONE,   1'b0, 1'b0, 5'd0, 5'd0},
            '{1'b0, ACT_COUNT,    KEY_ZERO,      1'b1, 1'b0, 5'd3, 5'd0},
            '{1'b1, ACT_INSERT,   KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd2},  // below occupancy
            '{1'b0, ACT_INSERT,   32'sh1234_5678, 1'b0, 1'b0, 5'd0, 5'd0}, // full, dropped
            '{1'b0, ACT_DUMP,     KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd0},  // two keys only
            '{1'b0, ACT_SEARCH,   KEY_NEG_ONE,   1'b1, 1'b1, 5'd0, 5'd0},
            '{1'b1, ACT_INSERT,   KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd0},  // capacity zero
            '{1'b0, ACT_DUMP,     KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd0},  // no output
            '{1'b0, ACT_COUNT,    KEY_ZERO,      1'b1, 1'b0, 5'd3, 5'd0},
            '{1'b0, ACT_SEARCH,   KEY_ONE,       1'b1, 1'b1, 5'd0, 5'd0},
            '{1'b1, ACT_INSERT,   KEY_ZERO,      1'b0, 1'b0, 5'd0, 5'd31}, // saturates at 16
            '{1'b0, ACT_INSERT,   KEY_MIN + 1,   1'b0, 1'b0, 5'd0, 5'd0}
        };

        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (steps[i])
        begin
            if (steps[i].is_cfg)
                set_capacity(steps[i].cap);
            else
                send_item(steps[i].act, steps[i].key, steps[i].typed, steps[i].t_found,
                          steps[i].t_occ, next_gap());
        end

        // Random phases: fill with the capacity saturated at 16, shrink capacity below the
        // occupancy, zero it, then run at one, the default and a random setting.
        phase_cap  = '{5'd31, 5'd3, 5'd0, 5'd1, CAP_RESET, 5'(($urandom_range(0, 31)))};
        insert_pct = '{75, 35, 30, 30, 50, 45};
        for (int p = 0; p < PHASES; p++)
        begin
            set_capacity(phase_cap[p]);
            // pool: keys held now (so removes and searches hit) plus fresh ones
            key_pool.delete();
            for (int i = 0; i < held_count; i++)
                key_pool.push_back(held_keys[i]);
            key_pool.push_back(KEY_MIN);
            key_pool.push_back(KEY_MAX);
            key_pool.push_back(KEY_ZERO);
            key_pool.push_back(KEY_NEG_ONE);
            for (int i = 0; i < 16; i++)
            begin
                if (i % 2 == 0)
                    key_pool.push_back($urandom());
                else
                    key_pool.push_back($signed({16'($urandom_range(0, 15) - 8), 16'h0000}));
            end

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < insert_pct[p])
                    act = ACT_INSERT;
                else
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 7)
                        act = ACT_REMOVE;
                    else if (pick < 12)
                        act = ACT_SEARCH;
                    else if (pick < 15)
                        act = ACT_DUMP;
                    else if (pick < 18)
                        act = ACT_COUNT;
                    else
                        act = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
                end
                if ($urandom_range(0, 99) < 15)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                send_item(act, k, 1'b0, 1'b0, '0, next_gap());
            end
        end

        wait_idle(TAIL_CYCLES);
        if (!failed)
            $display("** sorted_unique_list: PASSED **");
        else
            $display("** sorted_unique_list: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
